@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the wheel speed pid rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define WSPID_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition in one cycle implies a condition in the next
`define WSPID_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hw/rtl/wspid_pkg.sv @@
// types, widths and codes of the wheel speed pid with integral separation
// no dependencies; used by every rtl file of the block
package wspid_pkg;

  localparam int Channels = 4;
  localparam int ChanW    = (Channels > 1) ? $clog2(Channels) : 1;

  localparam int SpeedW  = 16;
  localparam int WheelW  = 2;
  localparam int GainW   = 16;
  localparam int LimW    = 15;
  localparam int ErrW    = SpeedW + 1;
  localparam int DiffW   = ErrW + 1;
  localparam int SumW    = 32;
  localparam int WgtW    = 9;
  localparam int FracW   = 8;
  localparam int DivNumW = LimW + FracW;
  localparam int DivCntW = $clog2(WgtW + 1);
  localparam int MulAW   = 32;
  localparam int MulBW   = GainW + WgtW + 1;
  localparam int ProdW   = MulAW + MulBW;
  localparam int AccW    = 60;
  localparam int DriveW  = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 16;

  localparam logic [WgtW-1:0]   WgtFull     = WgtW'(256);
  localparam logic [LimW-1:0]   OuterLimRst = LimW'(20);
  localparam logic [LimW-1:0]   InnerLimRst = LimW'(5);
  localparam logic [DriveW-1:0] DriveMax    = 16'h7fff;
  localparam logic [DriveW-1:0] DriveMin    = 16'h8000;
  localparam logic [SumW-1:0]   SumMax      = 32'h7fff_ffff;
  localparam logic [SumW-1:0]   SumMin      = 32'h8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    RegGainProp   = 3'd0,
    RegGainInteg  = 3'd1,
    RegGainDeriv  = 3'd2,
    RegOuterLimit = 3'd3,
    RegInnerLimit = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StLoad,
    StDiv,
    StMulP,
    StMulD,
    StMulIw,
    StMulIs,
    StMulEnd,
    StFin
  } pid_state_e;

  typedef struct packed {
    logic                     func;
    logic [WheelW-1:0]        wheel;
    logic signed [SpeedW-1:0] target_speed;
    logic signed [SpeedW-1:0] measured_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [DriveW-1:0] drive;
    logic [WheelW-1:0]        drive_wheel;
  } out_item_t;

  // control of the shared multiplier and accumulator
  typedef struct packed {
    logic clr;   // zero the accumulator
    logic mul;   // capture a product
    logic keep;  // product goes into the accumulator next cycle
    logic shl;   // product is scaled by 256 before the add
  } mac_ctrl_t;

endpackage

@@ hw/rtl/wheel_speed_pid_integral_separation_unit.sv @@
// top level of the four-channel wheel speed pid with integral separation
// depends on wspid_pkg, wspid_div, wspid_mac and assert_macros.svh
`include "assert_macros.svh"

// One transaction runs one control step for a wheel or clears its state and
// always returns one drive value. The unit takes one item at a time: a control
// step runs from load through the multiply states to finish, with a divide
// state after load when |error| lies in the weighted band between inner and
// outer limit, where the 9-bit weight comes from a restoring divider at one
// bit per cycle; a clear or an unknown wheel goes from load to finish. The
// four products of the output go one after the other through a single 32x26
// multiplier with a registered product. The result sits in an output register,
// so the next transaction is taken while the last drive value waits.
module wheel_speed_pid_integral_separation_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  wspid_pkg::in_item_t              in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output wspid_pkg::out_item_t             out_data_o,
  input  logic                             cfg_we_i,
  input  logic [wspid_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [wspid_pkg::CfgW-1:0]       cfg_data_i
);
  import wspid_pkg::*;

  pid_state_e state_q, state_d;

  logic signed [GainW-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
  logic [LimW-1:0]         outer_q, inner_q;

  logic signed [SumW-1:0] error_sum_q [Channels];
  logic signed [ErrW-1:0] prior_error_q [Channels];

  logic                    func_q;
  logic [WheelW-1:0]       wheel_q;
  logic signed [ErrW-1:0]  err_q;
  logic signed [SumW-1:0]  sum_q;
  logic signed [DiffW-1:0] diff_q;
  logic [WgtW-1:0]         w_q;

  logic                    out_valid_q;
  out_item_t               out_data_q;

  // load-stage decode
  logic [ChanW-1:0]        idx;
  logic                    wheel_ok, skip;
  logic signed [SumW-1:0]  sum_rd, sum_new;
  logic signed [ErrW-1:0]  prior_rd;
  logic signed [SumW:0]    sum_ext;
  logic [ErrW-1:0]         mag;
  logic                    over, under, mid;
  logic [LimW-1:0]         den, span;
  logic [WgtW-1:0]         w_load;

  // shared units
  mac_ctrl_t               mac_ctrl;
  logic signed [MulAW-1:0] mac_a;
  logic signed [MulBW-1:0] mac_b;
  logic signed [ProdW-1:0] mac_prod;
  logic signed [AccW-1:0]  mac_acc;
  logic                    div_start, div_busy;
  logic [WgtW-1:0]         div_quot;

  logic                    out_load, in_fire;
  logic [DriveW-1:0]       drive_sat;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i & in_ready_o;

  assign idx      = ChanW'(wheel_q);
  assign wheel_ok = (32'(wheel_q) < Channels);
  assign skip     = func_q | ~wheel_ok;
  assign sum_rd   = error_sum_q[idx];
  assign prior_rd = prior_error_q[idx];

  assign mag   = err_q[ErrW-1] ? ErrW'(-err_q) : ErrW'(err_q);
  assign over  = mag > {2'b00, outer_q};
  assign under = mag < {2'b00, inner_q};
  assign mid   = ~over & ~under;
  assign den   = outer_q - inner_q;
  assign span  = outer_q - mag[LimW-1:0];

  // saturating accumulate of the error, skipped above the outer limit
  assign sum_ext = (SumW+1)'(sum_rd) + (SumW+1)'(err_q);
  always_comb begin
    sum_new = sum_rd;
    if (!over) begin
      if (sum_ext[SumW] != sum_ext[SumW-1]) begin
        sum_new = sum_ext[SumW] ? SumMin : SumMax;
      end else begin
        sum_new = sum_ext[SumW-1:0];
      end
    end
  end

  assign w_load = (!over && under) ? WgtFull : '0;

  // floor of acc / 65536, clipped to 16 bits
  always_comb begin
    if ((&mac_acc[AccW-1:31]) || !(|mac_acc[AccW-1:31])) begin
      drive_sat = mac_acc[31:16];
    end else begin
      drive_sat = mac_acc[AccW-1] ? DriveMin : DriveMax;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    mac_ctrl  = '0;
    mac_a     = '0;
    mac_b     = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StLoad;
      end
      StLoad: begin
        if (skip) begin
          state_d = StFin;
        end else if (mid && den != '0) begin
          div_start = 1'b1;
          state_d   = StDiv;
        end else begin
          state_d = StMulP;
        end
      end
      StDiv: begin
        if (!div_busy) state_d = StMulP;
      end
      StMulP: begin
        mac_ctrl = '{clr: 1'b1, mul: 1'b1, keep: 1'b1, shl: 1'b1};
        mac_a    = MulAW'(err_q);
        mac_b    = MulBW'(gain_prop_q);
        state_d  = StMulD;
      end
      StMulD: begin
        mac_ctrl = '{clr: 1'b0, mul: 1'b1, keep: 1'b1, shl: 1'b1};
        mac_a    = MulAW'(diff_q);
        mac_b    = MulBW'(gain_deriv_q);
        state_d  = StMulIw;
      end
      StMulIw: begin
        // integral gain times weight first, kept out of the sum
        mac_ctrl = '{clr: 1'b0, mul: 1'b1, keep: 1'b0, shl: 1'b0};
        mac_a    = MulAW'({1'b0, w_q});
        mac_b    = MulBW'(gain_integ_q);
        state_d  = StMulIs;
      end
      StMulIs: begin
        mac_ctrl = '{clr: 1'b0, mul: 1'b1, keep: 1'b1, shl: 1'b0};
        mac_a    = sum_q;
        mac_b    = mac_prod[MulBW-1:0];
        state_d  = StMulEnd;
      end
      StMulEnd: begin
        state_d = StFin;
      end
      StFin: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= '0;
      gain_integ_q <= '0;
      gain_deriv_q <= '0;
      outer_q      <= OuterLimRst;
      inner_q      <= InnerLimRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGainProp:   gain_prop_q  <= cfg_data_i;
        RegGainInteg:  gain_integ_q <= cfg_data_i;
        RegGainDeriv:  gain_deriv_q <= cfg_data_i;
        RegOuterLimit: outer_q      <= cfg_data_i[LimW-1:0];
        RegInnerLimit: inner_q      <= cfg_data_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  // per-wheel state, written in the load cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        error_sum_q[i]   <= '0;
        prior_error_q[i] <= '0;
      end
    end else if (state_q == StLoad && wheel_ok) begin
      if (func_q) begin
        error_sum_q[idx]   <= '0;
        prior_error_q[idx] <= '0;
      end else begin
        error_sum_q[idx]   <= sum_new;
        prior_error_q[idx] <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q  <= in_data_i.func;
      wheel_q <= in_data_i.wheel;
      err_q   <= ErrW'(in_data_i.target_speed) - ErrW'(in_data_i.measured_speed);
    end
    if (state_q == StLoad) begin
      sum_q  <= sum_new;
      diff_q <= DiffW'(err_q) - DiffW'(prior_rd);
      w_q    <= w_load;
    end
    if (state_q == StDiv && !div_busy) begin
      w_q <= div_quot;
    end
    if (out_load) begin
      out_data_q.drive       <= skip ? '0 : drive_sat;
      out_data_q.drive_wheel <= wheel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  wspid_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({span, {FracW{1'b0}}}),
    .den_i   (den),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  wspid_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .prod_o (mac_prod),
    .acc_o  (mac_acc)
  );

  `WSPID_ASSERT_NEXT(AcceptGoesBusy, in_fire, !in_ready_o, "input taken twice in a row")
  `WSPID_ASSERT(WeightInRange, state_q == StMulIw |-> w_q <= WgtFull, "integral weight above one")
  `WSPID_ASSERT(ResultFromFinish, $rose(out_valid_o) |-> $past(state_q == StFin), "result without finish")

endmodule

@@ hw/rtl/wspid_div.sv @@
// restoring divider for the integral weight, one quotient bit per cycle
// depends on wspid_pkg and assert_macros.svh
`include "assert_macros.svh"

module wspid_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [wspid_pkg::DivNumW-1:0]  num_i,
  input  logic [wspid_pkg::LimW-1:0]     den_i,
  output logic                           busy_o,
  output logic [wspid_pkg::WgtW-1:0]     quot_o
);
  import wspid_pkg::*;

  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [LimW-1:0]    den_q;
  logic [LimW-1:0]    rem_q, rem_d;
  logic [WgtW-1:0]    num_q;
  logic [WgtW-1:0]    quot_q;
  logic [LimW:0]      trial;
  logic               ge;

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;

  // partial remainder stays below the divisor, so it fits the limit width
  assign trial = {rem_q, num_q[WgtW-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign rem_d = ge ? LimW'(trial - {1'b0, den_q}) : trial[LimW-1:0];

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = DivCntW'(WgtW);
    end else if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_i;
      rem_q  <= LimW'(num_i[DivNumW-1:WgtW]);
      num_q  <= num_i[WgtW-1:0];
      quot_q <= '0;
    end else if (busy_o) begin
      rem_q  <= rem_d;
      num_q  <= {num_q[WgtW-2:0], 1'b0};
      quot_q <= {quot_q[WgtW-2:0], ge};
    end
  end

  `WSPID_ASSERT(DivStartIdle, start_i |-> !busy_o, "divider started while busy")
  `WSPID_ASSERT_NEXT(DivRunsDown, busy_o && !start_i, cnt_q == $past(cnt_q) - 1'b1, "divider count skipped")

endmodule

@@ hw/rtl/wspid_mac.sv @@
// shared signed multiplier with a registered product and a wide accumulator
// depends on wspid_pkg
module wspid_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wspid_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [wspid_pkg::MulAW-1:0]  a_i,
  input  logic signed [wspid_pkg::MulBW-1:0]  b_i,
  output logic signed [wspid_pkg::ProdW-1:0]  prod_o,
  output logic signed [wspid_pkg::AccW-1:0]   acc_o
);
  import wspid_pkg::*;

  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [AccW-1:0]  acc_q, addend;
  logic                    add_q, shl_q;

  assign prod_d = a_i * b_i;
  assign addend = shl_q ? {prod_q[AccW-FracW-1:0], {FracW{1'b0}}} : AccW'(prod_q);

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_q <= 1'b0;
      shl_q <= 1'b0;
    end else begin
      add_q <= ctrl_i.mul & ctrl_i.keep;
      shl_q <= ctrl_i.shl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (add_q) begin
      acc_q <= acc_q + addend;
    end
  end

endmodule
